@@ hw/rtl/sbba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbba_pkg
// Shared types and constants for the scaled bitmap blit address map.
// ----------------------------------------------------------------------------
package sbba_pkg;

    localparam int MAX_IMAGE_DIM = 4096;
    localparam int POS_W  = 13;                            // row/col/dest widths
    localparam int CW     = $clog2(MAX_IMAGE_DIM + 1);     // crop/image dim width
    localparam int QW     = $clog2(MAX_IMAGE_DIM);         // source index width
    localparam int DW     = POS_W + CW;                    // dividend width
    localparam int SW     = CW + 2;                        // padded stride width
    localparam int OFF_W  = 26;
    localparam int SUM_W  = (QW + SW + 1 > OFF_W) ? QW + SW + 1 : OFF_W;
    localparam int LAT    = QW + 3;                        // accept to strobe

    // register indexes
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_CROP_WIDTH   = 3'd2;
    localparam logic [2:0] REG_CROP_HEIGHT  = 3'd3;
    localparam logic [2:0] REG_DRAW_WIDTH   = 3'd4;
    localparam logic [2:0] REG_DRAW_HEIGHT  = 3'd5;
    localparam logic [2:0] REG_DEST_WIDTH   = 3'd6;
    localparam logic [2:0] REG_DEST_HEIGHT  = 3'd7;

    // one word moving through the divider stages
    typedef struct packed {
        logic             ok;
        logic [POS_W-1:0] dx;
        logic [POS_W-1:0] dy;
        logic [DW-1:0]    nr;
        logic [DW-1:0]    nc;
        logic [QW-1:0]    qr;
        logic [QW-1:0]    qc;
    } div_word_t;

endpackage

@@ hw/rtl/sbba_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbba_div
// Pipelined restoring divider, one quotient bit per stage, for the row and
// column scale factors in parallel.
// ----------------------------------------------------------------------------
module sbba_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  sbba_pkg::div_word_t           in_word,
    input  logic [sbba_pkg::POS_W-1:0]    div_row,
    input  logic [sbba_pkg::POS_W-1:0]    div_col,
    output logic                          out_valid,
    output sbba_pkg::div_word_t           out_word
);

    logic                valid_reg [sbba_pkg::QW+1];
    sbba_pkg::div_word_t word_reg  [sbba_pkg::QW+1];

    assign valid_reg[0] = in_valid;
    assign word_reg[0]  = in_word;

    genvar k;
    generate
        for (k = 0; k < sbba_pkg::QW; k++)
        begin : g_stage
            localparam int B = sbba_pkg::QW - 1 - k;
            logic [sbba_pkg::DW-1:0] dr, dc;
            sbba_pkg::div_word_t     w_next;
            sbba_pkg::div_word_t     w_reg;
            logic                    v_reg;

            assign dr = sbba_pkg::DW'(div_row) << B;
            assign dc = sbba_pkg::DW'(div_col) << B;

            // compare and subtract the shifted row and column divisors
            always_comb
            begin
                w_next = word_reg[k];
                if (word_reg[k].nr >= dr)
                begin
                    w_next.nr    = word_reg[k].nr - dr;
                    w_next.qr[B] = 1'b1;
                end
                if (word_reg[k].nc >= dc)
                begin
                    w_next.nc    = word_reg[k].nc - dc;
                    w_next.qc[B] = 1'b1;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg <= 1'b0;
                else
                    v_reg <= valid_reg[k];
            end

            always_ff @(posedge clk)
            begin
                w_reg <= w_next;
            end

            assign valid_reg[k+1] = v_reg;
            assign word_reg[k+1]  = w_reg;
        end
    endgenerate

    assign out_valid = valid_reg[sbba_pkg::QW];
    assign out_word  = word_reg[sbba_pkg::QW];

endmodule

@@ hw/rtl/scaled_bmp_blit_address_map.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_bmp_blit_address_map
// Maps a destination pixel of a scaled blit back to a source byte offset.
// An accepted pixel passes the entry register, one divider stage per source
// index bit, the product register and the output register to the strobe.
// Throughput: one pixel per cycle; busy stays low, results are never held.
// Reset clears config and valid registers, emptying the pipeline; data regs are not reset.
// ----------------------------------------------------------------------------
module scaled_bmp_blit_address_map (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [12:0] out_row,
    input  logic [12:0] out_col,
    input  logic signed [13:0] origin_x,
    input  logic signed [13:0] origin_y,
    output logic        result_valid,
    output logic        write_enable,
    output logic [25:0] source_offset,
    output logic [12:0] dest_x,
    output logic [12:0] dest_y,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [13:0] cfg_data
);

    localparam int CW = sbba_pkg::CW;
    localparam int QW = sbba_pkg::QW;

    logic [12:0] image_width_reg, crop_width_reg, crop_height_reg;
    logic [12:0] draw_width_reg, draw_height_reg, dest_width_reg, dest_height_reg;
    logic signed [13:0] image_height_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= '0;
            image_height_reg <= '0;
            crop_width_reg   <= '0;
            crop_height_reg  <= '0;
            draw_width_reg   <= '0;
            draw_height_reg  <= '0;
            dest_width_reg   <= '0;
            dest_height_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                sbba_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[12:0];
                sbba_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                sbba_pkg::REG_CROP_WIDTH:   crop_width_reg   <= cfg_data[12:0];
                sbba_pkg::REG_CROP_HEIGHT:  crop_height_reg  <= cfg_data[12:0];
                sbba_pkg::REG_DRAW_WIDTH:   draw_width_reg   <= cfg_data[12:0];
                sbba_pkg::REG_DRAW_HEIGHT:  draw_height_reg  <= cfg_data[12:0];
                sbba_pkg::REG_DEST_WIDTH:   dest_width_reg   <= cfg_data[12:0];
                sbba_pkg::REG_DEST_HEIGHT:  dest_height_reg  <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // derived geometry; user keeps it static while items flow, not enforced here
    logic [13:0]         habs;
    logic                bad_image, use_crop, flip;
    logic [CW-1:0]       iw, ih, cw, ch;
    logic [12:0]         ow, oh;
    logic [sbba_pkg::SW-1:0] stride;

    always_comb
    begin
        habs      = image_height_reg[13] ? 14'(-image_height_reg) : image_height_reg;
        bad_image = (image_width_reg == '0) || (habs == '0)
                 || (14'(image_width_reg) > 14'(sbba_pkg::MAX_IMAGE_DIM))
                 || (habs > 14'(sbba_pkg::MAX_IMAGE_DIM));
        flip      = !image_height_reg[13] && (habs != '0);
        iw        = CW'(image_width_reg);
        ih        = CW'(habs);
        use_crop  = (crop_width_reg != '0) && (crop_height_reg != '0);
        cw        = iw;
        ch        = ih;
        if (use_crop)
        begin
            if (14'(crop_width_reg) < 14'(image_width_reg))
                cw = CW'(crop_width_reg);
            if (14'(crop_height_reg) < habs)
                ch = CW'(crop_height_reg);
        end
        ow     = (draw_width_reg  != '0) ? draw_width_reg  : 13'(cw);
        oh     = (draw_height_reg != '0) ? draw_height_reg : 13'(ch);
        stride = sbba_pkg::SW'(((sbba_pkg::SW'(iw) * 3) + 3) >> 2) << 2;
    end

    // entry stage: bounds, clipping and scale products
    logic signed [14:0]  dx_s, dy_s;
    sbba_pkg::div_word_t in_word;
    sbba_pkg::div_word_t s0_reg;
    logic                s0_valid_reg;

    always_comb
    begin
        dx_s           = 15'(origin_x) + $signed({2'b00, out_col});
        dy_s           = 15'(origin_y) + $signed({2'b00, out_row});
        in_word        = '0;
        in_word.ok     = !bad_image && (out_row < oh) && (out_col < ow)
                      && !dx_s[14] && (dx_s[13:0] < {1'b0, dest_width_reg})
                      && !dy_s[14] && (dy_s[13:0] < {1'b0, dest_height_reg});
        in_word.dx     = dx_s[12:0];
        in_word.dy     = dy_s[12:0];
        in_word.nr     = sbba_pkg::DW'(out_row) * sbba_pkg::DW'(ch);
        in_word.nc     = sbba_pkg::DW'(out_col) * sbba_pkg::DW'(cw);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else
            s0_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s0_reg <= in_word;
    end

    // scale division
    logic                div_valid;
    sbba_pkg::div_word_t div_word;

    sbba_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_valid_reg),
        .in_word   (s0_reg),
        .div_row   (oh),
        .div_col   (ow),
        .out_valid (div_valid),
        .out_word  (div_word)
    );

    // row clamp and flip, row-stride product and column product
    logic [CW-1:0]             sr_c, sr_f;
    logic [QW-1:0]             sc_c;
    logic                      m_valid_reg, m_ok_reg;
    logic [QW+sbba_pkg::SW-1:0] m_row_reg;
    logic [QW+1:0]             m_col_reg;
    logic [12:0]               m_dx_reg, m_dy_reg;

    always_comb
    begin
        sr_c = CW'(div_word.qr);
        if (sr_c >= ih)
            sr_c = ih - 1'b1;
        sr_f = flip ? (ih - 1'b1 - sr_c) : sr_c;
        sc_c = div_word.qc;
        if (CW'(sc_c) >= cw)
            sc_c = QW'(cw - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        m_ok_reg  <= div_word.ok;
        m_row_reg <= (QW+sbba_pkg::SW)'(sr_f[QW-1:0]) * (QW+sbba_pkg::SW)'(stride);
        m_col_reg <= (QW+2)'(sc_c) * (QW+2)'(3);
        m_dx_reg  <= div_word.dx;
        m_dy_reg  <= div_word.dy;
    end

    // final add and output register
    logic [sbba_pkg::SUM_W-1:0] sum;
    logic        o_valid_reg, o_we_reg;
    logic [25:0] o_off_reg;
    logic [12:0] o_dx_reg, o_dy_reg;

    assign sum = sbba_pkg::SUM_W'(m_row_reg) + sbba_pkg::SUM_W'(m_col_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else
            o_valid_reg <= m_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        o_we_reg  <= m_ok_reg;
        o_off_reg <= m_ok_reg ? sum[25:0] : '0;
        o_dx_reg  <= m_ok_reg ? m_dx_reg : '0;
        o_dy_reg  <= m_ok_reg ? m_dy_reg : '0;
    end

    assign result_valid  = o_valid_reg;
    assign write_enable  = o_we_reg;
    assign source_offset = o_off_reg;
    assign dest_x        = o_dx_reg;
    assign dest_y        = o_dy_reg;

    // checks
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(sbba_pkg::LAT) result_valid)
        else $error("accepted word produced no result");
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !write_enable |-> source_offset == '0 && dest_x == '0
                                         && dest_y == '0)
        else $error("no-write result carries nonzero fields");
    a_clip: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && write_enable |-> dest_x < dest_width_reg
                                        && dest_y < dest_height_reg)
        else $error("write outside destination");

endmodule
